// ----- hdl/stwa_pkg.sv -----
// Shared types, codes and constants of the session table with aging.
`default_nettype none
package stwa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned SLOT_W          = 6;
  localparam logic [31:0] TOMBSTONE_CODE  = 32'd999999999;
  localparam logic [31:0] AGE_LIMIT_RESET = 32'd36000000;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD       = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_FIND_USE  = 3'd3,
    OP_FIND_PEEK = 3'd4,
    OP_SWEEP     = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_ADDED        = 4'd0,
    ST_DUPLICATE    = 4'd1,
    ST_FULL         = 4'd2,
    ST_REMOVED      = 4'd3,
    ST_NOT_FOUND    = 4'd4,
    ST_FOUND        = 4'd5,
    ST_AGED         = 4'd6,
    ST_NOTHING_AGED = 4'd7,
    ST_CLEARED      = 4'd8,
    ST_INVALID      = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_TOMB,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic issue;
    logic tomb;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_nop;
    logic needs_scan;
    logic scan_last;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ----- hdl/stwa_ctrl.sv -----
// Controller state machine that sequences the table scan of each request.
`default_nettype none
module stwa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire stwa_pkg::ctrl_stat_t stat_i,
  output stwa_pkg::ctrl_cmd_t     cmd_o,
  output logic                    busy_o
);
  import stwa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_nop) begin
          state_d = S_IDLE;
        end else if (stat_i.needs_scan) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_TOMB;
      end
      S_TOMB: begin
        cmd_o.tomb = 1'b1;
        state_d    = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/stwa_datapath.sv -----
// Datapath with the entry memories, occupancy flags, scan pipeline and result register.
`default_nettype none
module stwa_datapath #(
  parameter int unsigned TABLE_DEPTH = stwa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire stwa_pkg::ctrl_cmd_t  cmd_i,
  output stwa_pkg::ctrl_stat_t      stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic [2:0]           opcode_i,
  input  wire logic [31:0]          key_code_i,
  input  wire logic [63:0]          host_tag_i,
  input  wire logic [31:0]          remote_handle_i,
  input  wire logic [31:0]          now_ms_i,
  output logic                      res_valid_o,
  output logic [3:0]                status_o,
  output logic [stwa_pkg::SLOT_W-1:0] slot_o,
  output logic [31:0]               freed_code_o,
  output logic [31:0]               freed_remote_o,
  output logic                      last_o
);
  import stwa_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic [31:0] code_mem   [TABLE_DEPTH];
  logic [63:0] host_mem   [TABLE_DEPTH];
  logic [31:0] remote_mem [TABLE_DEPTH];
  logic [31:0] stamp_mem  [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid_q, used_q;
  logic [31:0] limit_q;

  logic [2:0]  op_q;
  logic [31:0] key_q, remote_q, now_q;
  logic [63:0] host_q;
  logic        key_zero_q;

  logic [IW-1:0] cnt_q, idx_q;
  logic          dv_q;
  logic [31:0]   code_rd_q, remote_rd_q, stamp_rd_q;
  logic [63:0]   host_rd_q;

  logic          hit_q, host_eq_q, free_q, pend_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, pend_idx_q;
  logic [31:0]   pend_code_q, pend_remote_q;

  logic          ent_valid, ent_used, ent_hit, aged;
  logic [31:0]   age;
  logic          tomb_we, add_we, code_we;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_code;

  logic                res_v_d;
  status_e             status_d;
  logic [SLOT_W-1:0]   slot_d;
  logic [31:0]         code_d, remote_d;
  logic                last_d;

  assign stat_o.is_nop     = op_q > OP_SWEEP;
  assign stat_o.needs_scan = (op_q == OP_SWEEP) ||
      ((op_q inside {OP_ADD, OP_REMOVE, OP_FIND_USE, OP_FIND_PEEK}) && !key_zero_q);
  assign stat_o.scan_last  = cnt_q == IW'(TABLE_DEPTH - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AGE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      key_q      <= key_code_i;
      host_q     <= host_tag_i;
      remote_q   <= remote_handle_i;
      now_q      <= now_ms_i;
      key_zero_q <= key_code_i == '0;
    end
  end

  assign ent_valid = valid_q[idx_q];
  assign ent_used  = used_q[idx_q];
  assign ent_hit   = ent_valid && (code_rd_q == key_q);
  assign age       = now_q - stamp_rd_q;
  assign aged      = dv_q && (op_q == OP_SWEEP) && ent_valid && !ent_used && (age > limit_q);

  assign tomb_we = cmd_i.tomb && (op_q == OP_ADD) && !key_zero_q && hit_q && !host_eq_q;
  assign add_we  = cmd_i.finish && (op_q == OP_ADD) && !key_zero_q &&
                   !(hit_q && host_eq_q) && free_q;
  assign code_we = tomb_we || add_we;
  assign wr_addr = cmd_i.tomb ? hit_idx_q : free_idx_q;
  assign wr_code = cmd_i.tomb ? TOMBSTONE_CODE : key_q;

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[wr_addr] <= wr_code;
    end
    if (add_we) begin
      host_mem[wr_addr]   <= host_q;
      remote_mem[wr_addr] <= remote_q;
      stamp_mem[wr_addr]  <= now_q;
    end
    if (cmd_i.issue) begin
      code_rd_q   <= code_mem[cnt_q];
      host_rd_q   <= host_mem[cnt_q];
      remote_rd_q <= remote_mem[cnt_q];
      stamp_rd_q  <= stamp_mem[cnt_q];
      idx_q       <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      dv_q   <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      dv_q <= cmd_i.issue;
      if (cmd_i.accept) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        pend_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (dv_q && ent_hit) begin
          hit_q <= 1'b1;
        end
        if (dv_q && !ent_valid) begin
          free_q <= 1'b1;
        end
        if (aged) begin
          pend_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_q && ent_hit && !hit_q) begin
      hit_idx_q <= idx_q;
      host_eq_q <= host_rd_q == host_q;
    end
    if (dv_q && !ent_valid && !free_q) begin
      free_idx_q <= idx_q;
    end
    if (aged) begin
      pend_idx_q    <= idx_q;
      pend_code_q   <= code_rd_q;
      pend_remote_q <= remote_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      if (cmd_i.finish && (op_q == OP_CLEAR)) begin
        valid_q <= '0;
        used_q  <= '0;
      end
      if (aged) begin
        valid_q[idx_q] <= 1'b0;
        used_q[idx_q]  <= 1'b0;
      end
      if (cmd_i.finish && !key_zero_q && hit_q) begin
        if (op_q == OP_REMOVE) begin
          valid_q[hit_idx_q] <= 1'b0;
          used_q[hit_idx_q]  <= 1'b0;
        end else if (op_q == OP_FIND_USE) begin
          used_q[hit_idx_q] <= 1'b1;
        end
      end
      if (add_we) begin
        valid_q[free_idx_q] <= 1'b1;
        used_q[free_idx_q]  <= 1'b0;
      end
    end
  end

  always_comb begin
    res_v_d  = 1'b0;
    status_d = ST_ADDED;
    slot_d   = '0;
    code_d   = '0;
    remote_d = '0;
    last_d   = 1'b0;
    if (aged && pend_q) begin
      res_v_d  = 1'b1;
      status_d = ST_AGED;
      slot_d   = SLOT_W'(pend_idx_q);
      code_d   = pend_code_q;
      remote_d = pend_remote_q;
    end
    if (cmd_i.finish) begin
      res_v_d = 1'b1;
      last_d  = 1'b1;
      case (op_q)
        OP_CLEAR: begin
          status_d = ST_CLEARED;
        end
        OP_SWEEP: begin
          if (pend_q) begin
            status_d = ST_AGED;
            slot_d   = SLOT_W'(pend_idx_q);
            code_d   = pend_code_q;
            remote_d = pend_remote_q;
          end else begin
            status_d = ST_NOTHING_AGED;
          end
        end
        OP_ADD: begin
          if (key_zero_q) begin
            status_d = ST_INVALID;
          end else if (hit_q && host_eq_q) begin
            status_d = ST_DUPLICATE;
            slot_d   = SLOT_W'(hit_idx_q);
          end else if (free_q) begin
            status_d = ST_ADDED;
            slot_d   = SLOT_W'(free_idx_q);
          end else begin
            status_d = ST_FULL;
          end
        end
        OP_REMOVE, OP_FIND_USE, OP_FIND_PEEK: begin
          if (key_zero_q) begin
            status_d = ST_INVALID;
          end else if (!hit_q) begin
            status_d = ST_NOT_FOUND;
          end else begin
            status_d = (op_q == OP_REMOVE) ? ST_REMOVED : ST_FOUND;
            slot_d   = SLOT_W'(hit_idx_q);
          end
        end
        default: begin
          res_v_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o       <= status_d;
    slot_o         <= slot_d;
    freed_code_o   <= code_d;
    freed_remote_o <= remote_d;
    last_o         <= last_d;
  end

endmodule
`default_nettype wire

// ----- hdl/session_table_with_aging_unit.sv -----
// Top level of the session table with aging: controller and datapath.
//
// A request is taken at a rising edge with start_i high and busy_o low; the
// opcode, key, host tag, remote handle and tick are sampled there. Each result
// appears on the result ports for one cycle, marked by res_valid_o, with
// last_o set on the final result of the request.
// Every table operation except clear and an invalid key walks the entries one
// per cycle through the registered read port of the entry memories; clear and
// a zero key skip the walk, and unknown opcodes give no result. The final
// result appears in the cycle in which busy_o falls. Sweep results for freed
// entries stream out while the walk proceeds, each delayed until the next aged
// entry or the end. The age limit is written through cfg_we_i and cfg_wdata_i;
// the user must write it only while idle, as the block does not enforce this.
// Reset empties the table at once and loads the default age limit.
// The receiver cannot stall, so results are never held back.
`default_nettype none
module session_table_with_aging_unit #(
  parameter int unsigned TABLE_DEPTH = stwa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] key_code_i,
  input  wire logic [63:0] host_tag_i,
  input  wire logic [31:0] remote_handle_i,
  input  wire logic [31:0] now_ms_i,
  output logic             res_valid_o,
  output logic [3:0]       status_o,
  output logic [stwa_pkg::SLOT_W-1:0] slot_o,
  output logic [31:0]      freed_code_o,
  output logic [31:0]      freed_remote_o,
  output logic             last_o
);
  import stwa_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  stwa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  stwa_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .key_code_i      (key_code_i),
    .host_tag_i      (host_tag_i),
    .remote_handle_i (remote_handle_i),
    .now_ms_i        (now_ms_i),
    .res_valid_o     (res_valid_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .freed_code_o    (freed_code_o),
    .freed_remote_o  (freed_remote_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_session_table_with_aging_unit.sv -----
// Self-checking testbench for the session table with aging, with a predicting scoreboard.
`default_nettype none
module tb_session_table_with_aging_unit;
  import stwa_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned KEY_POOL    = 12;
  localparam int unsigned HOST_POOL   = 3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE      = TABLE_DEPTH + 16;
  localparam logic [2:0]  OP_SPARE_LO = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       code;
    logic [31:0]       remote;
    logic              last;
  } reply_t;

  class session_ledger;
    logic [31:0] codes   [TABLE_DEPTH];
    logic [63:0] hosts   [TABLE_DEPTH];
    logic [31:0] remotes [TABLE_DEPTH];
    logic [31:0] stamps  [TABLE_DEPTH];
    bit          used_marks [TABLE_DEPTH];
    logic [31:0] age_limit;
    reply_t      due_replies [$];
    int unsigned fails;

    function new();
      foreach (codes[i]) begin
        codes[i]      = '0;
        hosts[i]      = '0;
        remotes[i]    = '0;
        stamps[i]     = '0;
        used_marks[i] = 1'b0;
      end
      age_limit = AGE_LIMIT_RESET;
      fails     = 0;
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    function int first_slot(logic [31:0] code);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (codes[i] == code) return i;
      end
      return -1;
    endfunction

    function void queue_reply(status_e status, int slot, logic [31:0] code,
                              logic [31:0] remote, logic last);
      reply_t r;
      r.status = status;
      r.slot   = slot[SLOT_W-1:0];
      r.code   = code;
      r.remote = remote;
      r.last   = last;
      due_replies.push_back(r);
    endfunction

    function void take_request(logic [2:0] op, logic [31:0] key, logic [63:0] host,
                               logic [31:0] remote, logic [31:0] now);
      int     hit;
      int     spot;
      reply_t held;
      bit     have_held;
      have_held = 1'b0;
      case (op)
        OP_CLEAR: begin
          foreach (codes[i]) begin
            codes[i]      = '0;
            used_marks[i] = 1'b0;
          end
          queue_reply(ST_CLEARED, 0, '0, '0, 1'b1);
        end
        OP_SWEEP: begin
          foreach (codes[i]) begin
            if (codes[i] != '0 && !used_marks[i] && (now - stamps[i]) > age_limit) begin
              if (have_held) due_replies.push_back(held);
              held.status   = ST_AGED;
              held.slot     = i[SLOT_W-1:0];
              held.code     = codes[i];
              held.remote   = remotes[i];
              held.last     = 1'b0;
              have_held     = 1'b1;
              codes[i]      = '0;
              used_marks[i] = 1'b0;
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            due_replies.push_back(held);
          end else begin
            queue_reply(ST_NOTHING_AGED, 0, '0, '0, 1'b1);
          end
        end
        OP_ADD, OP_REMOVE, OP_FIND_USE, OP_FIND_PEEK: begin
          if (key == '0) begin
            queue_reply(ST_INVALID, 0, '0, '0, 1'b1);
          end else begin
            hit = first_slot(key);
            if (op == OP_ADD) begin
              if (hit >= 0 && hosts[hit] == host) begin
                queue_reply(ST_DUPLICATE, hit, '0, '0, 1'b1);
              end else begin
                if (hit >= 0) codes[hit] = TOMBSTONE_CODE;
                spot = first_slot('0);
                if (spot < 0) begin
                  queue_reply(ST_FULL, 0, '0, '0, 1'b1);
                end else begin
                  codes[spot]      = key;
                  hosts[spot]      = host;
                  remotes[spot]    = remote;
                  stamps[spot]     = now;
                  used_marks[spot] = 1'b0;
                  queue_reply(ST_ADDED, spot, '0, '0, 1'b1);
                end
              end
            end else if (hit < 0) begin
              queue_reply(ST_NOT_FOUND, 0, '0, '0, 1'b1);
            end else if (op == OP_REMOVE) begin
              codes[hit]      = '0;
              used_marks[hit] = 1'b0;
              queue_reply(ST_REMOVED, hit, '0, '0, 1'b1);
            end else begin
              if (op == OP_FIND_USE) used_marks[hit] = 1'b1;
              queue_reply(ST_FOUND, hit, '0, '0, 1'b1);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_reply(logic [3:0] status, logic [SLOT_W-1:0] slot,
                              logic [31:0] code, logic [31:0] remote, logic last);
      reply_t want;
      if (due_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d slot %0d", status, slot);
        fails++;
      end else begin
        want = due_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fails++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot);
          fails++;
        end
        if (code !== want.code) begin
          $error("freed_code: expected %h, actual %h", want.code, code);
          fails++;
        end
        if (remote !== want.remote) begin
          $error("freed_remote: expected %h, actual %h", want.remote, remote);
          fails++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          fails++;
        end
      end
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start_i         = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [31:0]       cfg_wdata_i     = '0;
  logic [2:0]        opcode_i        = '0;
  logic [31:0]       key_code_i      = '0;
  logic [63:0]       host_tag_i      = '0;
  logic [31:0]       remote_handle_i = '0;
  logic [31:0]       now_ms_i        = '0;
  logic              busy_o;
  logic              res_valid_o;
  logic [3:0]        status_o;
  logic [SLOT_W-1:0] slot_o;
  logic [31:0]       freed_code_o;
  logic [31:0]       freed_remote_o;
  logic              last_o;

  session_ledger ledger;
  logic [31:0]   key_pool  [KEY_POOL];
  logic [63:0]   host_pool [HOST_POOL];
  logic [31:0]   cur_now;

  session_table_with_aging_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .key_code_i     (key_code_i),
    .host_tag_i     (host_tag_i),
    .remote_handle_i(remote_handle_i),
    .now_ms_i       (now_ms_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .freed_code_o   (freed_code_o),
    .freed_remote_o (freed_remote_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) begin
      ledger.check_reply(status_o, slot_o, freed_code_o, freed_remote_o, last_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && busy_o === 1'b0) || res_valid_o === 1'b1 || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("session_table_with_aging_unit regression: fail");
    $finish;
  end

  task automatic send_req(logic [2:0] op, logic [31:0] key, logic [63:0] host,
                          logic [31:0] remote, logic [31:0] now);
    opcode_i        <= op;
    key_code_i      <= key;
    host_tag_i      <= host;
    remote_handle_i <= remote;
    now_ms_i        <= now;
    start_i         <= 1'b1;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    ledger.take_request(op, key, host, remote, now);
  endtask

  task automatic pause(int unsigned cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    pause(1);
    while (ledger.pending() != 0) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_age_limit(logic [31:0] value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.age_limit = value;
  endtask

  task automatic random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll >= 19) wait_idle();
    else if (roll >= 14) pause($urandom_range(6, 80));
    else if (roll >= 6) pause($urandom_range(1, 5));
  endtask

  task automatic random_request(output bit counted);
    int unsigned pick;
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] remote;
    logic [31:0] stamp;
    logic [63:0] host;
    pick    = $urandom_range(0, 99);
    key     = key_pool[$urandom_range(0, KEY_POOL - 1)];
    host    = host_pool[$urandom_range(0, HOST_POOL - 1)];
    remote  = $urandom();
    cur_now = cur_now + $urandom_range(0, 400);
    stamp   = cur_now;
    counted = 1'b1;
    if (pick < 38) begin
      op = OP_ADD;
    end else if (pick < 52) begin
      op = OP_FIND_USE;
    end else if (pick < 65) begin
      op = OP_FIND_PEEK;
    end else if (pick < 75) begin
      op = OP_REMOVE;
    end else if (pick < 88) begin
      op = OP_SWEEP;
      case ($urandom_range(0, 3))
        0: stamp = $urandom();
        1, 2: stamp = cur_now + ledger.age_limit - 32'd200 + $urandom_range(0, 400);
        default: begin
        end
      endcase
    end else if (pick < 91) begin
      op = OP_CLEAR;
    end else if (pick < 95) begin
      op  = 3'($urandom_range(int'(OP_ADD), int'(OP_FIND_PEEK)));
      key = '0;
    end else if (pick < 97) begin
      op      = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      key     = $urandom();
      host    = {$urandom(), $urandom()};
      counted = 1'b0;
    end else begin
      op   = 3'($urandom_range(int'(OP_ADD), int'(OP_FIND_PEEK)));
      key  = $urandom();
      host = {$urandom(), $urandom()};
    end
    send_req(op, key, host, remote, stamp);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned done_items;
    int unsigned burst;
    bit          counted;
    done_items = 0;
    while (done_items < count) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        random_request(counted);
        if (counted) done_items++;
      end
      random_gap();
    end
  endtask

  // Fills every slot, tries two adds against the full table, uses up to finds random entries, then ages the rest.
  task automatic fill_table(int unsigned finds);
    logic [31:0] fill_keys  [TABLE_DEPTH];
    logic [63:0] fill_hosts [TABLE_DEPTH];
    logic [31:0] seed_bits;
    send_req(OP_CLEAR, $urandom(), {$urandom(), $urandom()}, $urandom(), cur_now);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      seed_bits     = $urandom();
      fill_keys[i]  = {seed_bits[31:7], 1'b1, i[5:0]};
      fill_hosts[i] = {$urandom(), $urandom()};
      cur_now       = cur_now + 32'd1;
      send_req(OP_ADD, fill_keys[i], fill_hosts[i], $urandom(), cur_now);
      random_gap();
    end
    send_req(OP_ADD, fill_keys[5], ~fill_hosts[5], $urandom(), cur_now);
    seed_bits = $urandom();
    send_req(OP_ADD, {seed_bits[31:8], 1'b1, 7'd0}, {$urandom(), $urandom()}, $urandom(),
             cur_now);
    repeat (finds) begin
      send_req(OP_FIND_USE, fill_keys[$urandom_range(0, TABLE_DEPTH - 1)], '0, '0, cur_now);
    end
    send_req(OP_SWEEP, '0, '0, '0, cur_now + ledger.age_limit + 32'd100);
  endtask

  initial begin
    ledger = new();
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom();
      if (key_pool[i] == '0) key_pool[i] = 32'd1;
    end
    key_pool[0]  = 32'd1;
    key_pool[1]  = TOMBSTONE_CODE;
    key_pool[2]  = 32'hFFFF_FFFF;
    host_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    host_pool[1] = {$urandom(), $urandom()};
    host_pool[2] = {$urandom(), $urandom()};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(OP_FIND_PEEK, 32'd5, '0, '0, 32'd0);
    send_req(OP_ADD, '0, 64'h0123_4567_89AB_CDEF, 32'h1, 32'd10);
    send_req(OP_REMOVE, '0, '0, '0, 32'd10);
    send_req(OP_FIND_USE, '0, '0, '0, 32'd10);
    send_req(OP_FIND_PEEK, '0, '0, '0, 32'd10);
    send_req(OP_ADD, 32'd1, 64'h0123_4567_89AB_CDEF, 32'h0000_1234, 32'd100);
    send_req(OP_ADD, 32'd1, 64'h0123_4567_89AB_CDEF, 32'h0000_5678, 32'd150);
    send_req(OP_ADD, 32'd1, 64'hFEDC_BA98_7654_3210, 32'h0000_9ABC, 32'd200);
    send_req(OP_FIND_USE, 32'd1, '0, '0, 32'd210);
    send_req(OP_FIND_PEEK, TOMBSTONE_CODE, '0, '0, 32'd220);
    send_req(OP_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_ADD, TOMBSTONE_CODE, '0, 32'h0000_00A5, 32'd250);
    send_req(OP_REMOVE, 32'd1, '0, '0, 32'd260);
    send_req(OP_REMOVE, 32'd1, '0, '0, 32'd270);
    send_req(OP_SPARE_LO, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    send_req(OP_SPARE_HI, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    send_req(OP_SWEEP, '0, '0, '0, 32'd300);
    send_req(OP_SWEEP, '0, '0, '0, AGE_LIMIT_RESET - 32'd1);
    send_req(OP_SWEEP, '0, '0, '0, AGE_LIMIT_RESET);
    send_req(OP_SWEEP, '0, '0, '0, AGE_LIMIT_RESET + 32'd500);
    send_req(OP_CLEAR, '0, '0, '0, '0);
    send_req(OP_FIND_PEEK, 32'd1, '0, '0, '0);
    wait_idle();

    cur_now = $urandom();
    run_random(75);
    set_age_limit(32'd0);
    fill_table(0);
    run_random(70);
    set_age_limit(32'hFFFF_FFFF);
    run_random(60);
    set_age_limit($urandom_range(1000, 5000));
    fill_table(3);
    run_random(70);
    set_age_limit(AGE_LIMIT_RESET);
    run_random(40);

    pause(1);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (ledger.fails == 0) begin
      $display("session_table_with_aging_unit regression: pass");
    end else begin
      $display("session_table_with_aging_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/stwa_pkg.sv
hdl/stwa_ctrl.sv
hdl/stwa_datapath.sv
hdl/session_table_with_aging_unit.sv
tb/sv/tb_session_table_with_aging_unit.sv
